FILE: rtl/dvo_pkg.sv
`default_nettype none

package dvo_pkg;

    // field widths
    localparam int unsigned DAY_IN_W  = 6;
    localparam int unsigned MONTH_W   = 4;
    localparam int unsigned YEAR_W    = 14;
    localparam int unsigned OFFSET_W  = 18;
    localparam int unsigned DAY_OUT_W = 5;
    localparam int unsigned STATUS_W  = 3;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 14;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_YEAR_IN    = 3'd1,
        ST_BAD_DAY    = 3'd2,
        ST_BAD_MONTH  = 3'd3,
        ST_PAST_MONTH = 3'd4,
        ST_NOT_LEAP   = 3'd5,
        ST_YEAR_OUT   = 3'd6
    } t_status;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_YEAR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_YEAR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TODAY_DAY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TODAY_MONTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TODAY_YEAR  = 3'd4;

    // register reset values
    localparam logic [YEAR_W-1:0]    RST_MIN_YEAR    = 14'd1902;
    localparam logic [YEAR_W-1:0]    RST_MAX_YEAR    = 14'd2037;
    localparam logic [DAY_OUT_W-1:0] RST_TODAY_DAY   = 5'd1;
    localparam logic [MONTH_W-1:0]   RST_TODAY_MONTH = 4'd1;
    localparam logic [YEAR_W-1:0]    RST_TODAY_YEAR  = 14'd2000;

    // calendar constants
    localparam int unsigned DAYS_ERA    = 146097;   // days in 400 years
    localparam int unsigned DAYS_C4     = 1460;
    localparam int unsigned DAYS_C100   = 36524;
    localparam int unsigned DAYS_YEAR   = 365;
    localparam int unsigned YEAR_BIAS   = 400;      // keeps day numbers positive

    // reciprocal multipliers, exact over the value ranges used here
    localparam int unsigned SH25   = 18;
    localparam logic [13:0] K25    = 14'(((64'd1 << SH25) + 64'd24) / 64'd25);
    localparam int unsigned SHERA  = 41;
    localparam logic [23:0] KERA   =
        24'(((64'd1 << SHERA) + 64'(DAYS_ERA) - 64'd1) / 64'(DAYS_ERA));
    localparam int unsigned SHC4   = 29;
    localparam logic [18:0] KC4    =
        19'(((64'd1 << SHC4) + 64'(DAYS_C4) - 64'd1) / 64'(DAYS_C4));
    localparam int unsigned SHC100 = 34;
    localparam logic [18:0] KC100  =
        19'(((64'd1 << SHC100) + 64'(DAYS_C100) - 64'd1) / 64'(DAYS_C100));
    localparam int unsigned SHYR   = 27;
    localparam logic [18:0] KYR    =
        19'(((64'd1 << SHYR) + 64'(DAYS_YEAR) - 64'd1) / 64'(DAYS_YEAR));

    // longest length of each month, february as 29
    function automatic logic [DAY_OUT_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_OUT_W-1:0] len;
        unique case (m)
            4'd2:                     len = 5'd29;
            4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:       len = 5'd31;
            default:                  len = 5'd0;
        endcase
        return len;
    endfunction

    // first day of each month in a year that starts on march 1
    function automatic logic [8:0] march_start(input logic [MONTH_W-1:0] mp);
        logic [8:0] s;
        unique case (mp)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd92;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd184;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd245;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd337;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/date_validate_and_offset_top.sv
`default_nettype none

// channel   | direction | handshake                       | payload
// ----------+-----------+---------------------------------+---------------------------------
// s_axis    | in        | s_axis_tvalid / s_axis_tready   | day, month, year, day offset
// m_axis    | out       | m_axis_tvalid / m_axis_tready   | day, month, year; status in tuser
// cfg       | in        | i_cfg_valid / o_cfg_ready       | register index, write data
//
// eleven register stages, one word in and one word out per cycle while the output is not stalled
// the longest stage is the 24 x 23 bit reciprocal multiply that finds the 400-year era
// all stages advance together; a stalled output freezes the whole pipe, input ready follows
// i_rst_n (synchronous, active low) clears the stage valid bits and loads register defaults
// cfg writes are always taken (o_cfg_ready high); no clearing pass after reset

module date_validate_and_offset_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // [5:0] in_day, [9:6] in_month, [23:10] in_year, [41:24] day_offset, [47:42] zero
    input  wire logic [47:0] s_axis_tdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [4:0] out_day, [8:5] out_month, [22:9] out_year, [23] zero
    output logic [23:0]      m_axis_tdata,
    // [2:0] status
    output logic [2:0]       m_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [13:0] i_cfg_data
);

    localparam int unsigned NSTAGE = 11;

    // configuration registers
    logic [13:0] r_min_year;
    logic [13:0] r_max_year;
    logic [4:0]  r_today_day;
    logic [3:0]  r_today_month;
    logic [13:0] r_today_year;

    // stage valid bits and the global advance
    logic [NSTAGE-1:0] r_vld;
    logic              en;

    // input word fields
    logic [5:0]         w_in_day;
    logic [3:0]         w_in_month;
    logic [13:0]        w_in_year;
    logic signed [17:0] w_in_off;

    // stage 1: substitution and checks
    logic [5:0]           n1_d;
    logic [3:0]           n1_m;
    logic [13:0]          n1_y;
    dvo_pkg::t_status     n1_st;
    dvo_pkg::t_status     r1_st;
    logic                 r1_feb29;
    logic                 r1_jf;
    logic [13:0]          r1_y;
    logic [3:0]           r1_mp;
    logic [4:0]           r1_dm1;
    logic signed [17:0]   r1_off;

    // stage 2: centuries of biased year and of the input year
    logic [14:0]          n2_yb;
    logic [26:0]          n2_prod_yb;
    logic [25:0]          n2_prod_y;
    dvo_pkg::t_status     r2_st;
    logic                 r2_feb29;
    logic [13:0]          r2_y;
    logic [14:0]          r2_yb;
    logic [7:0]           r2_cyb;
    logic [7:0]           r2_cy;
    logic [3:0]           r2_mp;
    logic [4:0]           r2_dm1;
    logic signed [17:0]   r2_off;

    // stage 3: leap test and day count of the year start
    logic                 n3_leap;
    dvo_pkg::t_status     r3_st;
    logic [22:0]          r3_zy;
    logic [8:0]           r3_doy;
    logic signed [17:0]   r3_off;

    // stage 4: add offset
    logic [23:0]          n4_sum;
    dvo_pkg::t_status     r4_st;
    logic [22:0]          r4_w;

    // stage 5: era
    logic [46:0]          n5_prod;
    dvo_pkg::t_status     r5_st;
    logic [22:0]          r5_w;
    logic [5:0]           r5_era;

    // stage 6: day of era
    logic [22:0]          n6_doe;
    dvo_pkg::t_status     r6_st;
    logic [5:0]           r6_era;
    logic [17:0]          r6_doe;

    // stage 7: leap corrections
    logic [36:0]          n7_pa;
    logic [36:0]          n7_pb;
    logic [17:0]          n7_t;
    dvo_pkg::t_status     r7_st;
    logic [5:0]           r7_era;
    logic [17:0]          r7_doe;
    logic [17:0]          r7_t;

    // stage 8: year of era
    logic [36:0]          n8_prod;
    dvo_pkg::t_status     r8_st;
    logic [5:0]           r8_era;
    logic [17:0]          r8_doe;
    logic [8:0]           r8_yoe;

    // stage 9: day of year
    logic [1:0]           n9_cent;
    logic [17:0]          n9_ystart;
    logic [17:0]          n9_doy;
    dvo_pkg::t_status     r9_st;
    logic [5:0]           r9_era;
    logic [8:0]           r9_yoe;
    logic [8:0]           r9_doy;

    // stage 10: month index and result year
    logic [3:0]           n10_mp;
    dvo_pkg::t_status     r10_st;
    logic [3:0]           r10_mp;
    logic [8:0]           r10_doy;
    logic [15:0]          r10_ry;

    // stage 11: output word
    logic [4:0]           n11_d;
    logic [3:0]           n11_m;
    dvo_pkg::t_status     n11_st;
    dvo_pkg::t_status     r_out_st;
    logic [4:0]           r_out_day;
    logic [3:0]           r_out_month;
    logic [13:0]          r_out_year;

    assign en            = !r_vld[NSTAGE-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_vld[NSTAGE-1];
    assign m_axis_tdata  = {1'b0, r_out_year, r_out_month, r_out_day};
    assign m_axis_tuser  = r_out_st;

    assign w_in_day   = s_axis_tdata[5:0];
    assign w_in_month = s_axis_tdata[9:6];
    assign w_in_year  = s_axis_tdata[23:10];
    assign w_in_off   = $signed(s_axis_tdata[41:24]);

    // zero fields take today's date, then checks in priority order
    always_comb begin
        n1_d = (w_in_day == 6'd0) ? {1'b0, r_today_day} : w_in_day;
        n1_m = (w_in_month == 4'd0) ? r_today_month : w_in_month;
        n1_y = (w_in_year == 14'd0) ? r_today_year : w_in_year;
        if (n1_y < r_min_year || n1_y > r_max_year) begin
            n1_st = dvo_pkg::ST_YEAR_IN;
        end else if (n1_d == 6'd0 || n1_d > 6'd31) begin
            n1_st = dvo_pkg::ST_BAD_DAY;
        end else if (n1_m == 4'd0 || n1_m > 4'd12) begin
            n1_st = dvo_pkg::ST_BAD_MONTH;
        end else if (n1_d > {1'b0, dvo_pkg::month_len(n1_m)}) begin
            n1_st = dvo_pkg::ST_PAST_MONTH;
        end else begin
            n1_st = dvo_pkg::ST_OK;
        end
    end

    // january and february count with the previous year; bias by 400 years
    assign n2_yb      = 15'({1'b0, r1_y}) + 15'(dvo_pkg::YEAR_BIAS) - 15'(r1_jf);
    assign n2_prod_yb = 27'(n2_yb[14:2]) * 27'(dvo_pkg::K25);
    assign n2_prod_y  = 26'(r1_y[13:2]) * 26'(dvo_pkg::K25);

    // gregorian leap rule from year / 100
    assign n3_leap = (r2_y[1:0] == 2'd0)
                  && ((r2_y[13:2] != 12'(r2_cy) * 12'd25) || (r2_cy[1:0] == 2'd0));

    assign n4_sum = $signed({1'b0, r3_zy}) + $signed({15'd0, r3_doy})
                  + $signed({{6{r3_off[17]}}, r3_off});

    assign n5_prod = 47'(r4_w) * 47'(dvo_pkg::KERA);
    assign n6_doe  = r5_w - 23'(r5_era) * 23'(dvo_pkg::DAYS_ERA);

    assign n7_pa = 37'(r6_doe) * 37'(dvo_pkg::KC4);
    assign n7_pb = 37'(r6_doe) * 37'(dvo_pkg::KC100);
    assign n7_t  = r6_doe - 18'(n7_pa[35:dvo_pkg::SHC4])
                 + 18'(n7_pb[36:dvo_pkg::SHC100])
                 - 18'(r6_doe == 18'(dvo_pkg::DAYS_ERA - 1));

    assign n8_prod = 37'(r7_t) * 37'(dvo_pkg::KYR);

    always_comb begin
        if (r8_yoe >= 9'd300) begin
            n9_cent = 2'd3;
        end else if (r8_yoe >= 9'd200) begin
            n9_cent = 2'd2;
        end else if (r8_yoe >= 9'd100) begin
            n9_cent = 2'd1;
        end else begin
            n9_cent = 2'd0;
        end
        n9_ystart = 18'(r8_yoe) * 18'(dvo_pkg::DAYS_YEAR) + 18'(r8_yoe[8:2]) - 18'(n9_cent);
        n9_doy    = r8_doe - n9_ystart;
    end

    // month index from independent compares against the march-based table
    always_comb begin
        n10_mp = 4'd0;
        for (int i = 1; i < 12; i++) begin
            if (r9_doy >= dvo_pkg::march_start(4'(i))) begin
                n10_mp = 4'(i);
            end
        end
    end

    always_comb begin
        n11_d = 5'(r10_doy - dvo_pkg::march_start(r10_mp) + 9'd1);
        n11_m = (r10_mp < 4'd10) ? r10_mp + 4'd3 : r10_mp - 4'd9;
        n11_st = r10_st;
        if (r10_st == dvo_pkg::ST_OK
            && ($signed(r10_ry) < $signed({2'b00, r_min_year})
             || $signed(r10_ry) > $signed({2'b00, r_max_year}))) begin
            n11_st = dvo_pkg::ST_YEAR_OUT;
        end
    end

    // control and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld         <= '0;
            r_min_year    <= dvo_pkg::RST_MIN_YEAR;
            r_max_year    <= dvo_pkg::RST_MAX_YEAR;
            r_today_day   <= dvo_pkg::RST_TODAY_DAY;
            r_today_month <= dvo_pkg::RST_TODAY_MONTH;
            r_today_year  <= dvo_pkg::RST_TODAY_YEAR;
        end else begin
            if (en) begin
                r_vld <= {r_vld[NSTAGE-2:0], s_axis_tvalid};
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    dvo_pkg::CFG_MIN_YEAR:    r_min_year    <= i_cfg_data;
                    dvo_pkg::CFG_MAX_YEAR:    r_max_year    <= i_cfg_data;
                    dvo_pkg::CFG_TODAY_DAY:   r_today_day   <= i_cfg_data[4:0];
                    dvo_pkg::CFG_TODAY_MONTH: r_today_month <= i_cfg_data[3:0];
                    dvo_pkg::CFG_TODAY_YEAR:  r_today_year  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            // stage 1
            r1_st    <= n1_st;
            r1_feb29 <= (n1_m == 4'd2) && (n1_d == 6'd29);
            r1_jf    <= (n1_m <= 4'd2);
            r1_y     <= n1_y;
            r1_mp    <= (n1_m > 4'd2) ? n1_m - 4'd3 : n1_m + 4'd9;
            r1_dm1   <= 5'(n1_d - 6'd1);
            r1_off   <= w_in_off;
            // stage 2
            r2_st    <= r1_st;
            r2_feb29 <= r1_feb29;
            r2_y     <= r1_y;
            r2_yb    <= n2_yb;
            r2_cyb   <= n2_prod_yb[25:dvo_pkg::SH25];
            r2_cy    <= n2_prod_y[25:dvo_pkg::SH25];
            r2_mp    <= r1_mp;
            r2_dm1   <= r1_dm1;
            r2_off   <= r1_off;
            // stage 3
            r3_st    <= (r2_st == dvo_pkg::ST_OK && r2_feb29 && !n3_leap)
                        ? dvo_pkg::ST_NOT_LEAP : r2_st;
            r3_zy    <= 23'(r2_yb) * 23'(dvo_pkg::DAYS_YEAR) + 23'(r2_yb[14:2])
                        - 23'(r2_cyb) + 23'(r2_cyb[7:2]);
            r3_doy   <= dvo_pkg::march_start(r2_mp) + 9'(r2_dm1);
            r3_off   <= r2_off;
            // stage 4
            r4_st    <= r3_st;
            r4_w     <= n4_sum[22:0];
            // stage 5
            r5_st    <= r4_st;
            r5_w     <= r4_w;
            r5_era   <= n5_prod[46:dvo_pkg::SHERA];
            // stage 6
            r6_st    <= r5_st;
            r6_era   <= r5_era;
            r6_doe   <= n6_doe[17:0];
            // stage 7
            r7_st    <= r6_st;
            r7_era   <= r6_era;
            r7_doe   <= r6_doe;
            r7_t     <= n7_t;
            // stage 8
            r8_st    <= r7_st;
            r8_era   <= r7_era;
            r8_doe   <= r7_doe;
            r8_yoe   <= n8_prod[35:dvo_pkg::SHYR];
            // stage 9
            r9_st    <= r8_st;
            r9_era   <= r8_era;
            r9_yoe   <= r8_yoe;
            r9_doy   <= n9_doy[8:0];
            // stage 10, january and february belong to the next year
            r10_st   <= r9_st;
            r10_mp   <= n10_mp;
            r10_doy  <= r9_doy;
            r10_ry   <= 16'(r9_yoe) + 16'(r9_era) * 16'(dvo_pkg::YEAR_BIAS)
                        + 16'(n10_mp >= 4'd10) - 16'(dvo_pkg::YEAR_BIAS);
            // stage 11, fields zero on any error
            r_out_st <= n11_st;
            if (n11_st == dvo_pkg::ST_OK) begin
                r_out_day   <= n11_d;
                r_out_month <= n11_m;
                r_out_year  <= r10_ry[13:0];
            end else begin
                r_out_day   <= '0;
                r_out_month <= '0;
                r_out_year  <= '0;
            end
        end
    end

    // a stalled output holds every stage in place
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> r_vld == $past(r_vld))
        else $error("pipeline moved during stall");

    // error words carry zero date fields
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != dvo_pkg::ST_OK |-> m_axis_tdata == 24'd0)
        else $error("error word with nonzero date");

    // good words carry a plain date within the year limits
    a_ok_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == dvo_pkg::ST_OK |->
            r_out_day != 5'd0 && r_out_month != 4'd0 && r_out_month <= 4'd12
            && r_out_year >= r_min_year && r_out_year <= r_max_year)
        else $error("good word with bad date");

endmodule

`default_nettype wire
